// File: hw/rtl/lcmt_pkg.sv
// ---------------------------------------------------------------------------
// lcmt_pkg: shared definitions for the leader cluster mean tracker
// Action codes, register indexes, default sizes and reset values.
// ---------------------------------------------------------------------------
package lcmt_pkg;

    localparam int SLOT_COUNT_DEF  = 4;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [15:0] RADIUS_RST    = 16'd256;
    localparam logic [15:0] THRESHOLD_RST = 16'd5;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_LIST  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic REG_RADIUS    = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

endpackage

// File: hw/rtl/leader_cluster_mean_tracker.sv
// ---------------------------------------------------------------------------
// leader_cluster_mean_tracker
// Online leader clustering of Q8.8 points with running centroids per slot.
// ---------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  in      | i_in_valid / o_in_ready   | i_action, i_point_x, i_point_y
//  out     | o_out_valid / i_out_ready | o_valid_res .. o_last
//  cfg     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  One item at a time. An add scans up to SLOT_COUNT slots, visiting each
//  occupied slot in a scan and a compare state, then runs a bit-serial
//  restoring divide of the (16+COUNT_WIDTH)-bit sums (x and y in parallel).
//  Clear empties every slot and reports once; list walks the slots in order.
//  Synchronous active-low reset empties all slots at once. A stalled output
//  holds the sequencer until its transfer.
// ---------------------------------------------------------------------------
module leader_cluster_mean_tracker
    import lcmt_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_valid_res,
    output logic [1:0]         o_slot_index,
    output logic signed [15:0] o_centroid_x,
    output logic signed [15:0] o_centroid_y,
    output logic               o_joined,
    output logic               o_opened,
    output logic               o_dropped,
    output logic               o_slot_ready,
    output logic               o_all_ready,
    output logic               o_last
);

    localparam int IW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SW  = 16 + COUNT_WIDTH;          // sum width
    localparam int DCW = $clog2(SW);                // divide step counter
    localparam int TW  = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [IW-1:0]          LAST_SLOT = IW'(SLOT_COUNT - 1);
    localparam logic [DCW-1:0]         LAST_STEP = DCW'(SW - 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = {COUNT_WIDTH{1'b1}};

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SCAN  = 10'b0000000010,
        S_CMP   = 10'b0000000100,
        S_OPEN  = 10'b0000001000,
        S_ABS   = 10'b0000010000,
        S_DINIT = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_DFIN  = 10'b0010000000,
        S_ADDO  = 10'b0100000000,
        S_LIST  = 10'b1000000000
    } t_state;

    // clear shares the list state? no: it has its own flag below
    t_state r_state;
    logic   r_clr_pend;

    // configuration
    logic [15:0] r_radius, r_thresh;

    // slot stores
    logic signed [SW-1:0]      r_sum_x [SLOT_COUNT];
    logic signed [SW-1:0]      r_sum_y [SLOT_COUNT];
    logic [COUNT_WIDTH-1:0]    r_count [SLOT_COUNT];
    logic signed [15:0]        r_mean_x [SLOT_COUNT];
    logic signed [15:0]        r_mean_y [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]     r_ready;

    // item working registers
    logic signed [15:0] r_px, r_py;
    logic [IW-1:0]      r_slot;
    logic               r_join;
    logic [31:0]        r_r2;
    logic [32:0]        r_dx2, r_dy2;

    // bit-serial divider: dividend register doubles as quotient
    logic [SW-1:0]          r_dvx, r_dvy;
    logic [COUNT_WIDTH:0]   r_remx, r_remy;
    logic [COUNT_WIDTH-1:0] r_dcnt;
    logic                   r_negx, r_negy;
    logic [DCW-1:0]         r_step;

    // output register
    logic r_ov;

    logic [SLOT_COUNT-1:0] occ;
    logic                  any_empty, any_ready, more_ready, ld_ok;
    logic                  ld_res, add_rdy_set;
    logic [IW-1:0]         first_empty;
    logic signed [16:0]    dx, dy;
    logic signed [33:0]    dx_sq, dy_sq;
    logic [33:0]           d2;
    logic [COUNT_WIDTH:0]  shx, shy;

    always_comb begin
        any_empty   = 1'b0;
        first_empty = '0;
        more_ready  = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            occ[i] = (r_count[i] != '0);
            if (!occ[i]) begin
                any_empty   = 1'b1;
                first_empty = IW'(i);
            end
            if (r_ready[i] && (IW'(i) > r_slot)) begin
                more_ready = 1'b1;
            end
        end
        any_ready = |r_ready;
    end

    assign ld_ok = !r_ov || i_out_ready;

    // a saturated join still needs its ready mark set before reporting
    assign add_rdy_set = r_join && (TW'(r_count[r_slot]) >= TW'(r_thresh))
                         && !r_ready[r_slot];

    // result register loads this cycle
    assign ld_res = ld_ok && (((r_state == S_IDLE) && r_clr_pend)
                    || ((r_state == S_OPEN) && !any_empty)
                    || ((r_state == S_ADDO) && !add_rdy_set)
                    || ((r_state == S_LIST) && (!any_ready || r_ready[r_slot])));

    assign dx    = 17'(r_px) - 17'(r_mean_x[r_slot]);
    assign dy    = 17'(r_py) - 17'(r_mean_y[r_slot]);
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;
    assign d2    = {1'b0, r_dx2} + {1'b0, r_dy2};

    assign shx = {r_remx[COUNT_WIDTH-1:0], r_dvx[SW-1]};
    assign shy = {r_remy[COUNT_WIDTH-1:0], r_dvy[SW-1]};

    assign o_in_ready  = (r_state == S_IDLE) && !r_clr_pend;
    assign o_out_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clr_pend <= 1'b0;
            r_radius   <= RADIUS_RST;
            r_thresh   <= THRESHOLD_RST;
            r_ready    <= '0;
            r_ov       <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_RADIUS) begin
                    r_radius <= i_cfg_data;
                end else begin
                    r_thresh <= i_cfg_data;
                end
            end
            if (r_ov && i_out_ready && !ld_res) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (r_clr_pend) begin
                        // clear: empty every slot and report
                        if (ld_ok) begin
                            r_clr_pend   <= 1'b0;
                            r_ready      <= '0;
                            for (int i = 0; i < SLOT_COUNT; i++) begin
                                r_count[i] <= '0;
                            end
                            r_ov         <= 1'b1;
                            o_valid_res  <= 1'b0;
                            o_slot_index <= '0;
                            o_centroid_x <= '0;
                            o_centroid_y <= '0;
                            o_joined     <= 1'b0;
                            o_opened     <= 1'b0;
                            o_dropped    <= 1'b0;
                            o_slot_ready <= 1'b0;
                            o_all_ready  <= 1'b0;
                            o_last       <= 1'b1;
                        end
                    end else if (i_in_valid) begin
                        r_px   <= i_point_x;
                        r_py   <= i_point_y;
                        r_slot <= '0;
                        r_r2   <= r_radius * r_radius;
                        unique case (i_action)
                            ACT_ADD:   r_state    <= S_SCAN;
                            ACT_CLEAR: r_clr_pend <= 1'b1;
                            ACT_LIST:  r_state    <= S_LIST;
                            default:   r_state    <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (occ[r_slot]) begin
                        r_dx2   <= dx_sq[32:0];
                        r_dy2   <= dy_sq[32:0];
                        r_state <= S_CMP;
                    end else if (r_slot == LAST_SLOT) begin
                        r_state <= S_OPEN;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
                S_CMP: begin
                    if (d2 < {2'b00, r_r2}) begin
                        r_join  <= 1'b1;
                        r_state <= S_ABS;
                    end else if (r_slot == LAST_SLOT) begin
                        r_state <= S_OPEN;
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_OPEN: begin
                    if (any_empty) begin
                        r_slot  <= first_empty;
                        r_join  <= 1'b0;
                        r_state <= S_ABS;
                    end else if (ld_ok) begin
                        // every slot full: drop
                        r_ov         <= 1'b1;
                        o_valid_res  <= 1'b0;
                        o_slot_index <= '0;
                        o_centroid_x <= '0;
                        o_centroid_y <= '0;
                        o_joined     <= 1'b0;
                        o_opened     <= 1'b0;
                        o_dropped    <= 1'b1;
                        o_slot_ready <= 1'b0;
                        o_all_ready  <= &r_ready;
                        o_last       <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_ABS: begin
                    if (r_join && (r_count[r_slot] == CNT_MAX)) begin
                        r_state <= S_ADDO;       // saturated: store untouched
                    end else begin
                        if (r_join) begin
                            r_sum_x[r_slot] <= r_sum_x[r_slot] + SW'(r_px);
                            r_sum_y[r_slot] <= r_sum_y[r_slot] + SW'(r_py);
                        end else begin
                            r_sum_x[r_slot] <= SW'(r_px);
                            r_sum_y[r_slot] <= SW'(r_py);
                        end
                        r_count[r_slot] <= r_count[r_slot] + 1'b1;
                        r_state         <= S_DINIT;
                    end
                end
                S_DINIT: begin
                    r_negx  <= r_sum_x[r_slot][SW-1];
                    r_negy  <= r_sum_y[r_slot][SW-1];
                    r_dvx   <= r_sum_x[r_slot][SW-1] ? -r_sum_x[r_slot] : r_sum_x[r_slot];
                    r_dvy   <= r_sum_y[r_slot][SW-1] ? -r_sum_y[r_slot] : r_sum_y[r_slot];
                    r_remx  <= '0;
                    r_remy  <= '0;
                    r_dcnt  <= r_count[r_slot];
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (shx >= {1'b0, r_dcnt}) begin
                        r_remx <= shx - {1'b0, r_dcnt};
                        r_dvx  <= {r_dvx[SW-2:0], 1'b1};
                    end else begin
                        r_remx <= shx;
                        r_dvx  <= {r_dvx[SW-2:0], 1'b0};
                    end
                    if (shy >= {1'b0, r_dcnt}) begin
                        r_remy <= shy - {1'b0, r_dcnt};
                        r_dvy  <= {r_dvy[SW-2:0], 1'b1};
                    end else begin
                        r_remy <= shy;
                        r_dvy  <= {r_dvy[SW-2:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    // quotient magnitude never exceeds 32768
                    r_mean_x[r_slot] <= r_negx ? -r_dvx[15:0] : r_dvx[15:0];
                    r_mean_y[r_slot] <= r_negy ? -r_dvy[15:0] : r_dvy[15:0];
                    if (r_join && (TW'(r_count[r_slot]) >= TW'(r_thresh))) begin
                        r_ready[r_slot] <= 1'b1;
                    end
                    r_state <= S_ADDO;
                end
                S_ADDO: begin
                    // saturated join still gets the ready check
                    if (add_rdy_set) begin
                        r_ready[r_slot] <= 1'b1;
                    end else if (ld_ok) begin
                        r_ov         <= 1'b1;
                        o_valid_res  <= 1'b1;
                        o_slot_index <= 2'(r_slot);
                        o_centroid_x <= r_mean_x[r_slot];
                        o_centroid_y <= r_mean_y[r_slot];
                        o_joined     <= r_join;
                        o_opened     <= !r_join;
                        o_dropped    <= 1'b0;
                        o_slot_ready <= r_ready[r_slot];
                        o_all_ready  <= &r_ready;
                        o_last       <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_LIST: begin
                    if (!any_ready) begin
                        if (ld_ok) begin
                            r_ov         <= 1'b1;
                            o_valid_res  <= 1'b0;
                            o_slot_index <= '0;
                            o_centroid_x <= '0;
                            o_centroid_y <= '0;
                            o_joined     <= 1'b0;
                            o_opened     <= 1'b0;
                            o_dropped    <= 1'b0;
                            o_slot_ready <= 1'b0;
                            o_all_ready  <= &r_ready;
                            o_last       <= 1'b1;
                            r_state      <= S_IDLE;
                        end
                    end else if (r_ready[r_slot]) begin
                        if (ld_ok) begin
                            r_ov         <= 1'b1;
                            o_valid_res  <= 1'b1;
                            o_slot_index <= 2'(r_slot);
                            o_centroid_x <= r_mean_x[r_slot];
                            o_centroid_y <= r_mean_y[r_slot];
                            o_joined     <= 1'b0;
                            o_opened     <= 1'b0;
                            o_dropped    <= 1'b0;
                            o_slot_ready <= 1'b1;
                            o_all_ready  <= &r_ready;
                            o_last       <= !more_ready;
                            if (more_ready) begin
                                r_slot <= r_slot + 1'b1;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hw/rtl/lcmt_checker.sv
// ---------------------------------------------------------------------------
// lcmt_assert: port-level checks for the leader cluster mean tracker
// Watches the handshakes and result flags over time.
// ---------------------------------------------------------------------------
module lcmt_assert
    import lcmt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_action,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_valid_res,
    input logic       o_joined,
    input logic       o_opened,
    input logic       o_dropped
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before transfer");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dropped |-> !o_valid_res && !o_joined && !o_opened)
        else $error("dropped result carries data");

    a_join: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_joined || o_opened) |-> o_valid_res && !(o_joined && o_opened))
        else $error("join/open flags inconsistent");

    // an add keeps the block busy while it scans
    a_add_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action == ACT_ADD) |=> !o_in_ready)
        else $error("input taken during an add");

endmodule

bind leader_cluster_mean_tracker lcmt_assert u_lcmt_assert (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_action    (i_action),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_valid_res (o_valid_res),
    .o_joined    (o_joined),
    .o_opened    (o_opened),
    .o_dropped   (o_dropped)
);

// File: sim/lcmt_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lcmt_checker: result predictor and scoreboard for the cluster tracker
// Watches config writes and both channels, keeps its own copy of the slot
// state and compares every output transfer with the oldest expected result.
// ---------------------------------------------------------------------------
module lcmt_checker
    import lcmt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_action,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_valid_res,
    input  logic [1:0]         i_slot_index,
    input  logic signed [15:0] i_centroid_x,
    input  logic signed [15:0] i_centroid_y,
    input  logic               i_joined,
    input  logic               i_opened,
    input  logic               i_dropped,
    input  logic               i_slot_ready,
    input  logic               i_all_ready,
    input  logic               i_last,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_items,
    output int                 o_results
);

    localparam int          NSLOT     = SLOT_COUNT_DEF;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;

    typedef struct packed {
        logic               valid_res;
        logic [1:0]         slot;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic               joined;
        logic               opened;
        logic               dropped;
        logic               slot_ready;
        logic               all_ready;
        logic               last;
    } t_cluster_res;

    t_cluster_res       centroid_q[$];
    logic [15:0]        radius;
    logic [15:0]        threshold;
    longint             sum_x [NSLOT];
    longint             sum_y [NSLOT];
    logic [15:0]        cnt   [NSLOT];
    logic signed [15:0] mean_x[NSLOT];
    logic signed [15:0] mean_y[NSLOT];
    bit                 rdy   [NSLOT];

    assign o_pending = centroid_q.size();

    function automatic bit every_slot_ready();
        bit all;
        all = 1'b1;
        for (int i = 0; i < NSLOT; i++) all &= rdy[i];
        return all;
    endfunction

    function automatic t_cluster_res slot_res(int s, logic j, logic o, logic last);
        t_cluster_res r;
        r = '0;
        r.valid_res  = 1'b1;
        r.slot       = s[1:0];
        r.cx         = mean_x[s];
        r.cy         = mean_y[s];
        r.joined     = j;
        r.opened     = o;
        r.slot_ready = rdy[s];
        r.all_ready  = every_slot_ready();
        r.last       = last;
        return r;
    endfunction

    // fold one sample into a slot; a saturated count freezes the slot
    task automatic fold_point(int s, logic signed [15:0] x, logic signed [15:0] y);
        if (cnt[s] != COUNT_TOP) begin
            sum_x[s] += x;
            sum_y[s] += y;
            cnt[s]++;
            mean_x[s] = 16'(sum_x[s] / longint'(cnt[s]));
            mean_y[s] = 16'(sum_y[s] / longint'(cnt[s]));
        end
    endtask

    task automatic empty_slots();
        for (int i = 0; i < NSLOT; i++) begin
            sum_x[i] = 0; sum_y[i] = 0; cnt[i] = '0;
            mean_x[i] = '0; mean_y[i] = '0; rdy[i] = 1'b0;
        end
    endtask

    task automatic predict_centroids(t_action act, logic signed [15:0] x,
                                     logic signed [15:0] y);
        int           hit;
        int           lastslot;
        longint       dx, dy, r2;
        t_cluster_res r;
        hit = -1;
        lastslot = -1;
        r = '0;
        case (act)
            ACT_ADD: begin
                r2 = longint'(radius) * longint'(radius);
                for (int i = 0; i < NSLOT && hit < 0; i++) begin
                    if (cnt[i] != 0) begin
                        dx = longint'(x) - longint'(mean_x[i]);
                        dy = longint'(y) - longint'(mean_y[i]);
                        if (dx * dx + dy * dy < r2) hit = i;
                    end
                end
                if (hit >= 0) begin
                    fold_point(hit, x, y);
                    if (cnt[hit] >= threshold) rdy[hit] = 1'b1;
                    centroid_q.push_back(slot_res(hit, 1'b1, 1'b0, 1'b1));
                end else begin
                    for (int i = 0; i < NSLOT && hit < 0; i++)
                        if (cnt[i] == 0) hit = i;
                    if (hit >= 0) begin
                        fold_point(hit, x, y);
                        centroid_q.push_back(slot_res(hit, 1'b0, 1'b1, 1'b1));
                    end else begin
                        r.dropped   = 1'b1;
                        r.all_ready = every_slot_ready();
                        r.last      = 1'b1;
                        centroid_q.push_back(r);
                    end
                end
            end
            ACT_CLEAR: begin
                empty_slots();
                r.last = 1'b1;
                centroid_q.push_back(r);
            end
            ACT_LIST: begin
                for (int i = 0; i < NSLOT; i++) if (rdy[i]) lastslot = i;
                if (lastslot < 0) begin
                    r.all_ready = every_slot_ready();
                    r.last      = 1'b1;
                    centroid_q.push_back(r);
                end else begin
                    for (int i = 0; i < NSLOT; i++)
                        if (rdy[i])
                            centroid_q.push_back(slot_res(i, 1'b0, 1'b0, i == lastslot));
                end
            end
            default: ;  // unused action, no result
        endcase
    endtask

    always @(posedge i_clk) begin
        t_cluster_res got, exp_r;
        if (!i_rst_n) begin
            radius    = RADIUS_RST;
            threshold = THRESHOLD_RST;
            empty_slots();
            centroid_q.delete();
            o_errors  = 0;
            o_items   = 0;
            o_results = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_RADIUS) radius = i_cfg_data;
                else                           threshold = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                o_items++;
                predict_centroids(t_action'(i_action), i_point_x, i_point_y);
            end
            if (i_out_valid && i_out_ready) begin
                o_results++;
                got = {i_valid_res, i_slot_index, i_centroid_x, i_centroid_y, i_joined,
                       i_opened, i_dropped, i_slot_ready, i_all_ready, i_last};
                if (centroid_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("ERROR: unexpected result %p", got);
                end else begin
                    exp_r = centroid_q.pop_front();
                    if (got !== exp_r) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("ERROR: result mismatch\n  exp %p\n  got %p",
                                     exp_r, got);
                    end
                end
            end
        end
    end

endmodule

// File: sim/leader_cluster_mean_tracker_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// leader_cluster_mean_tracker_tb: top level of the cluster tracker bench
// Directed points at the coordinate extremes, then clustered random traffic
// under several radius / threshold settings with random stalls on both sides.
// ---------------------------------------------------------------------------
module leader_cluster_mean_tracker_tb;
    import lcmt_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;   // cycles without any transfer or config write
    localparam int LONG_HOLD      = 400;    // receiver hold-off for back-pressure
    localparam int DRAIN_WAIT     = 80;     // covers the longest add

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = 1'b0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_action = ACT_ADD;
    logic signed [15:0] i_point_x = '0;
    logic signed [15:0] i_point_y = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_valid_res;
    logic [1:0]         o_slot_index;
    logic signed [15:0] o_centroid_x;
    logic signed [15:0] o_centroid_y;
    logic               o_joined, o_opened, o_dropped;
    logic               o_slot_ready, o_all_ready, o_last;

    int errors, pending, items, results;
    bit hold_req = 1'b0;    // asks the receiver for one long hold-off
    int phases = 0;

    always #5 i_clk = ~i_clk;

    leader_cluster_mean_tracker u_top (.*);

    lcmt_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_action, .i_point_x, .i_point_y,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_valid_res(o_valid_res), .i_slot_index(o_slot_index),
        .i_centroid_x(o_centroid_x), .i_centroid_y(o_centroid_y),
        .i_joined(o_joined), .i_opened(o_opened), .i_dropped(o_dropped),
        .i_slot_ready(o_slot_ready), .i_all_ready(o_all_ready), .i_last(o_last),
        .o_errors(errors), .o_pending(pending), .o_items(items), .o_results(results)
    );

    // receiver: short random gaps, ready bursts, and one long hold on request
    initial begin
        int r, n;
        forever begin
            r = $urandom_range(0, 99);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (r < 25) begin
                i_out_ready <= 1'b0;
                n = (r < 3) ? $urandom_range(20, 60) : $urandom_range(1, 3);
                repeat (n) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                n = (r > 90) ? $urandom_range(30, 60) : $urandom_range(1, 4);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // watchdog: ends the run when nothing transfers for too long
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                idle = 0;
            else
                idle++;
        end
        $display("ERROR: watchdog expired, %0d results still pending", pending);
        $display("== FAIL ==");
        $finish;
    end

    task automatic write_reg(logic idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one input transfer, then a random gap (mostly none, sometimes long)
    task automatic push_point(t_action act, logic signed [15:0] x, logic signed [15:0] y);
        int r, gap;
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_point_x  <= x;
        i_point_y  <= y;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 80);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait for every expected result, then let any silent item finish
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767)  return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return 16'(v);
    endfunction

    // clustered random traffic around four centres, plus noise and other actions
    task automatic random_phase(int n, logic [15:0] radius, logic [15:0] thr);
        int cx[4], cy[4];
        int spread, r, c;
        write_reg(REG_RADIUS, radius);
        write_reg(REG_THRESHOLD, thr);
        phases++;
        spread = radius / 3 + 1;
        for (int i = 0; i < 4; i++) begin
            cx[i] = $urandom_range(0, 40000) - 20000;
            cy[i] = $urandom_range(0, 40000) - 20000;
        end
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            c = $urandom_range(0, 3);
            if (r < 62)
                push_point(ACT_ADD,
                           clamp16(cx[c] + $urandom_range(0, 2 * spread) - spread),
                           clamp16(cy[c] + $urandom_range(0, 2 * spread) - spread));
            else if (r < 70)
                push_point(ACT_ADD, clamp16(cx[c]), clamp16(cy[c]));
            else if (r < 78)
                push_point(ACT_ADD, 16'($urandom), 16'($urandom));
            else if (r < 90)
                push_point(ACT_LIST, 16'($urandom), 16'($urandom));
            else if (r < 95)
                push_point(ACT_CLEAR, 16'($urandom), 16'($urandom));
            else
                push_point(ACT_NONE, 16'($urandom), 16'($urandom));
        end
        settle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings (radius 1.0, threshold 5)
        push_point(ACT_LIST, 16'sd0, 16'sd0);             // nothing ready yet
        push_point(ACT_ADD, 16'sd0, 16'sd0);              // opens slot 0
        push_point(ACT_ADD, 16'sd10, -16'sd10);           // joins slot 0
        push_point(ACT_ADD, 16'sd32767, 16'sd32767);      // corner opens slot 1
        push_point(ACT_ADD, -16'sd32768, -16'sd32768);    // slot 2
        push_point(ACT_ADD, -16'sd32768, 16'sd32767);     // slot 3, all full
        push_point(ACT_ADD, 16'sd32767, -16'sd32768);     // no match, dropped
        push_point(ACT_ADD, -16'sd255, 16'sd0);           // just outside radius: dropped
        push_point(ACT_ADD, 16'sd256, 16'sd0);            // inside radius: joins slot 0
        push_point(ACT_ADD, -16'sd7, 16'sd3);             // count 4
        push_point(ACT_ADD, 16'sd1, 16'sd1);              // count 5, slot 0 ready
        push_point(ACT_LIST, 16'sd0, 16'sd0);
        push_point(ACT_NONE, 16'sd0, 16'sd0);             // ignored
        push_point(ACT_CLEAR, 16'sd0, 16'sd0);
        push_point(ACT_LIST, 16'sd0, 16'sd0);
        settle();

        // threshold zero: first merge makes a slot ready; all four ready
        write_reg(REG_THRESHOLD, 16'd0);
        for (int i = 0; i < 4; i++) begin
            push_point(ACT_ADD, 16'(i * 8000), -16'sd100);
            push_point(ACT_ADD, 16'(i * 8000 + 3), -16'sd98);
        end
        push_point(ACT_LIST, 16'sd0, 16'sd0);
        push_point(ACT_ADD, 16'sd20000, 16'sd20000);      // dropped with all ready
        settle();

        random_phase(31, 16'd0, 16'd1);        // zero radius: nothing ever merges
        hold_req = 1'b1;                       // back-pressure during this phase
        random_phase(31, 16'd1024, 16'd3);
        random_phase(31, 16'd65535, 16'd0);    // widest radius
        random_phase(31, 16'd300, 16'd65535);  // threshold out of reach
        random_phase(31, 16'd512, 16'd2);
        random_phase(31, 16'd2000, 16'd1);

        $display("Summary: %0d items and %0d results checked over %0d config phases,",
                 items, results, phases + 1);
        $display("         including extreme radius and threshold values and a long stall.");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
